@@ src/mmc_pkg.sv @@
// shared types, codes and transition table of the mower mode controller
package mmc_pkg;

   localparam int unsigned MODE_W = 4;
   localparam int unsigned CMD_W = 3;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned ELAPSED_W = 16;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [MODE_W-1:0] MODE_IDLE     = 4'd0;
   localparam logic [MODE_W-1:0] MODE_MOWING   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_DOCKING  = 4'd2;
   localparam logic [MODE_W-1:0] MODE_CHARGING = 4'd3;
   localparam logic [MODE_W-1:0] MODE_MANUAL   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_PAUSED   = 4'd5;
   localparam logic [MODE_W-1:0] MODE_SLEEP    = 4'd6;
   localparam logic [MODE_W-1:0] MODE_RAIN     = 4'd7;
   localparam logic [MODE_W-1:0] MODE_MAINT    = 4'd8;
   localparam logic [MODE_W-1:0] MODE_REMOTE   = 4'd9;
   localparam logic [MODE_W-1:0] MODE_ESTOP    = 4'd10;
   localparam logic [MODE_W-1:0] MODE_BORDER   = 4'd11;
   localparam logic [MODE_W-1:0] MODE_LIFTED   = 4'd12;
   localparam logic [MODE_W-1:0] MODE_TEST     = 4'd13;
   localparam logic [MODE_W-1:0] MODE_ERROR    = 4'd14;

   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DOCK      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ESTOP     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_MANUAL    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RESET_ERR = 3'd6;
   localparam logic [CMD_W-1:0] CMD_REQUEST   = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_DOCKING_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_BACKOFF  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAIN_WAIT       = 2'd2;

   localparam logic [TIME_W-1:0] DOCKING_TIMEOUT_RST = 32'd5000;
   localparam logic [TIME_W-1:0] BORDER_BACKOFF_RST  = 32'd2000;
   localparam logic [TIME_W-1:0] RAIN_WAIT_RST       = 32'd86400000;

   // allowed targets per source mode, bit n set means mode n may be entered
   localparam logic [15:0] ALLOW_TAB [16] = '{
      16'h2076, // idle
      16'h19A5, // mowing
      16'h0009, // docking
      16'h0003, // charging
      16'h0021, // manual
      16'h0013, // paused
      16'h0001, // sleep
      16'h0003, // rain
      16'h0001, // maint
      16'h0011, // remote
      16'h0001, // estop
      16'h0007, // border
      16'h0001, // lifted
      16'h0001, // test
      16'h0001, // error
      16'h0000
   };

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [MODE_W-1:0]  last_mode;
      logic [TIME_W-1:0]  timer;
      logic               estop_latch;
      logic               blade_en;
      logic               motor_en;
      logic               charger_en;
   } ctl_state_type;

   typedef struct packed {
      logic refused;
      logic halt;
      logic border;
   } ctl_flags_type;

   typedef struct packed {
      ctl_state_type st;
      ctl_flags_type fl;
   } ctl_work_type;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [MODE_W-1:0]    target_state;
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic                 lifted;
      logic                 battery_low;
      logic                 border_seen;
      logic                 battery_charged;
      logic                 docked;
      logic                 battery_full;
      logic                 charging_active;
   } req_item_type;

   typedef struct packed {
      logic [TIME_W-1:0] docking_timeout;
      logic [TIME_W-1:0] border_backoff;
      logic [TIME_W-1:0] rain_wait;
   } csr_regs_type;

   // one requested move with its exit and entry actions
   function automatic ctl_work_type mmc_request(input ctl_work_type w,
                                                input logic [MODE_W-1:0] to);
      ctl_work_type r;
      r = w;
      if (w.st.mode != to) begin
         if (to != MODE_ESTOP && !ALLOW_TAB[w.st.mode][to]) begin
            r.fl.refused = 1'b1;
         end else begin
            if (w.st.mode == MODE_CHARGING) r.st.charger_en = 1'b0;
            r.st.last_mode = w.st.mode;
            r.st.mode = to;
            r.st.timer = '0;
            case (to)
               MODE_MOWING: begin
                  r.st.blade_en = 1'b1;
                  r.st.motor_en = 1'b1;
               end
               MODE_DOCKING: begin
                  r.st.blade_en = 1'b0;
                  r.st.motor_en = 1'b1;
               end
               MODE_CHARGING: begin
                  r.st.blade_en = 1'b0;
                  r.st.motor_en = 1'b0;
                  r.st.charger_en = 1'b1;
               end
               MODE_ESTOP: begin
                  r.st.blade_en = 1'b0;
                  r.st.motor_en = 1'b0;
                  r.st.estop_latch = 1'b1;
                  r.fl.halt = 1'b1;
               end
               MODE_LIFTED: begin
                  r.st.blade_en = 1'b0;
                  r.st.motor_en = 1'b0;
                  r.fl.halt = 1'b1;
               end
               MODE_BORDER: begin
                  r.fl.border = 1'b1;
               end
               MODE_TEST: begin
                  r.fl.border = w.fl.border;
               end
               default: begin
                  r.st.blade_en = 1'b0;
                  r.st.motor_en = 1'b0;
               end
            endcase
         end
      end
      return r;
   endfunction

endpackage

@@ src/mmc_if.sv @@
// valid/ready channel interfaces for commands and results
interface mmc_req_if;
   logic                           valid;
   logic                           ready;
   logic [mmc_pkg::CMD_W-1:0]      cmd;
   logic [mmc_pkg::MODE_W-1:0]     target_state;
   logic [mmc_pkg::ELAPSED_W-1:0]  elapsed_ms;
   logic                           lifted;
   logic                           battery_low;
   logic                           border_seen;
   logic                           battery_charged;
   logic                           docked;
   logic                           battery_full;
   logic                           charging_active;

   modport source (
      output valid, cmd, target_state, elapsed_ms, lifted, battery_low, border_seen,
             battery_charged, docked, battery_full, charging_active,
      input  ready
   );
   modport sink (
      input  valid, cmd, target_state, elapsed_ms, lifted, battery_low, border_seen,
             battery_charged, docked, battery_full, charging_active,
      output ready
   );
endinterface

interface mmc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mmc_pkg::MODE_W-1:0]  mode;
   logic [mmc_pkg::MODE_W-1:0]  prior_mode;
   logic                        refused;
   logic                        blades_on;
   logic                        drive_on;
   logic                        charge_enable;
   logic                        halt_pulse;
   logic                        border_pulse;

   modport source (
      output valid, mode, prior_mode, refused, blades_on, drive_on, charge_enable,
             halt_pulse, border_pulse,
      input  ready
   );
   modport sink (
      input  valid, mode, prior_mode, refused, blades_on, drive_on, charge_enable,
             halt_pulse, border_pulse,
      output ready
   );
endinterface

@@ src/mmc_next.sv @@
// next mode controller state for one command or tick
module mmc_next (
   input  mmc_pkg::ctl_state_type cur,
   input  mmc_pkg::req_item_type  item,
   input  mmc_pkg::csr_regs_type  regs,
   output mmc_pkg::ctl_work_type  nxt
);
   import mmc_pkg::*;

   logic [TIME_W:0]   timer_sum;
   logic [TIME_W-1:0] timer_sat;
   logic              emerg;
   ctl_work_type      w;
   logic [MODE_W-1:0] back_to;

   assign timer_sum = {1'b0, cur.timer} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, item.elapsed_ms};
   assign timer_sat = timer_sum[TIME_W] ? {TIME_W{1'b1}} : timer_sum[TIME_W-1:0];
   assign emerg = item.lifted | cur.estop_latch;

   always_comb begin
      w.st = cur;
      w.fl = '0;
      back_to = cur.last_mode;
      case (item.cmd)
         CMD_TICK: begin
            w.st.timer = timer_sat;
            if (emerg && cur.mode != MODE_ESTOP) begin
               w = mmc_request(w, MODE_ESTOP);
            end else begin
               case (cur.mode)
                  MODE_MOWING: begin
                     if (item.border_seen) w = mmc_request(w, MODE_BORDER);
                     else if (item.lifted) w = mmc_request(w, MODE_LIFTED);
                     if (item.battery_low) w = mmc_request(w, MODE_DOCKING);
                     else if (item.border_seen) w = mmc_request(w, MODE_BORDER);
                  end
                  MODE_DOCKING: begin
                     if (w.st.timer > regs.docking_timeout) w = mmc_request(w, MODE_CHARGING);
                     if (item.battery_charged) w = mmc_request(w, MODE_MOWING);
                     else if (item.docked) w = mmc_request(w, MODE_CHARGING);
                  end
                  MODE_CHARGING: begin
                     if (!item.charging_active) w = mmc_request(w, MODE_IDLE);
                     if (item.battery_full) w = mmc_request(w, MODE_IDLE);
                     else if (!item.docked) w = mmc_request(w, MODE_DOCKING);
                  end
                  MODE_SLEEP: begin
                     if (item.battery_charged && item.docked) w = mmc_request(w, MODE_CHARGING);
                  end
                  MODE_RAIN: begin
                     if (w.st.timer > regs.rain_wait) w = mmc_request(w, MODE_IDLE);
                  end
                  MODE_BORDER: begin
                     if (w.st.timer > regs.border_backoff) w = mmc_request(w, MODE_MOWING);
                     if (!item.border_seen) w = mmc_request(w, MODE_MOWING);
                  end
                  MODE_LIFTED: begin
                     if (!item.lifted) w = mmc_request(w, MODE_IDLE);
                  end
                  default: begin
                     w.st.timer = timer_sat;
                  end
               endcase
            end
         end
         CMD_START: if (!emerg) w = mmc_request(w, MODE_MOWING);
         CMD_STOP: if (cur.mode == MODE_MOWING) w = mmc_request(w, MODE_IDLE);
         CMD_DOCK: if (!emerg) w = mmc_request(w, MODE_DOCKING);
         CMD_ESTOP: w = mmc_request(w, MODE_ESTOP);
         CMD_MANUAL: if (!emerg) w = mmc_request(w, MODE_MANUAL);
         CMD_RESET_ERR: begin
            if (cur.mode == MODE_ESTOP) begin
               w = mmc_request(w, back_to);
               // reaching the recorded mode releases the emergency latch
               if (w.st.mode == back_to) w.st.estop_latch = 1'b0;
            end
         end
         default: w = mmc_request(w, item.target_state);
      endcase
      nxt = w;
   end

endmodule

@@ src/mower_mode_controller.sv @@
// Mower mode controller top level: takes one command or tick per cycle and returns one
// registered result per transfer, in the cycle after it. Throughput is one item per clock,
// set by the single result register, which accepts a new item whenever it is empty or
// being drained in the same cycle. All mode moves of an item, including chained moves on a
// tick, are resolved in one pass of logic between the state and result registers. The
// user must write timeouts via the csr port only while idle; this is not enforced.
module mower_mode_controller (
   input  logic                              clock,
   input  logic                              reset,
   mmc_req_if.sink                           req_ch,
   mmc_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [mmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mmc_pkg::TIME_W-1:0]        csr_wdata
);
   import mmc_pkg::*;

   ctl_state_type state_ff;
   csr_regs_type  regs_ff;
   req_item_type  item;
   ctl_work_type  nxt;
   logic          xfer_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   ctl_state_type rsp_st_ff;
   ctl_flags_type rsp_fl_ff;

   assign item = '{cmd: req_ch.cmd, target_state: req_ch.target_state,
                   elapsed_ms: req_ch.elapsed_ms, lifted: req_ch.lifted,
                   battery_low: req_ch.battery_low, border_seen: req_ch.border_seen,
                   battery_charged: req_ch.battery_charged, docked: req_ch.docked,
                   battery_full: req_ch.battery_full,
                   charging_active: req_ch.charging_active};

   mmc_next u_next (
      .cur  (state_ff),
      .item (item),
      .regs (regs_ff),
      .nxt  (nxt)
   );

   // result register frees up when empty or taken this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign xfer_in = req_ch.valid && req_ch.ready;
   assign rsp_valid_in = xfer_in || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: MODE_IDLE, last_mode: MODE_IDLE, timer: '0,
                       estop_latch: 1'b0, blade_en: 1'b0, motor_en: 1'b0,
                       charger_en: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (xfer_in) state_ff <= nxt.st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{docking_timeout: DOCKING_TIMEOUT_RST,
                      border_backoff: BORDER_BACKOFF_RST,
                      rain_wait: RAIN_WAIT_RST};
      end else if (csr_we) begin
         case (csr_index)
            CSR_DOCKING_TIMEOUT: regs_ff.docking_timeout <= csr_wdata;
            CSR_BORDER_BACKOFF:  regs_ff.border_backoff <= csr_wdata;
            CSR_RAIN_WAIT:       regs_ff.rain_wait <= csr_wdata;
            default:             regs_ff <= regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (xfer_in) begin
         rsp_st_ff <= nxt.st;
         rsp_fl_ff <= nxt.fl;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.mode          = rsp_st_ff.mode;
   assign rsp_ch.prior_mode    = rsp_st_ff.last_mode;
   assign rsp_ch.refused       = rsp_fl_ff.refused;
   assign rsp_ch.blades_on     = rsp_st_ff.blade_en;
   assign rsp_ch.drive_on      = rsp_st_ff.motor_en;
   assign rsp_ch.charge_enable = rsp_st_ff.charger_en;
   assign rsp_ch.halt_pulse    = rsp_fl_ff.halt;
   assign rsp_ch.border_pulse  = rsp_fl_ff.border;

endmodule

@@ tb/mower_mode_controller_tb.sv @@
// self-checking testbench for the mower mode controller with its own mode predictor
module mower_mode_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mmc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned MAX_REPORTS = 100;

   // sensor flag positions as packed by make_item
   localparam logic [6:0] S_LIFTED   = 7'b1000000;
   localparam logic [6:0] S_BATLOW   = 7'b0100000;
   localparam logic [6:0] S_BORDER   = 7'b0010000;
   localparam logic [6:0] S_CHARGED  = 7'b0001000;
   localparam logic [6:0] S_DOCKED   = 7'b0000100;
   localparam logic [6:0] S_FULL     = 7'b0000010;
   localparam logic [6:0] S_CHARGING = 7'b0000001;
   localparam logic [6:0] S_NONE     = 7'b0000000;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [MODE_W-1:0] prior;
      logic              refused;
      logic              blades;
      logic              drive;
      logic              charge;
      logic              halt;
      logic              border;
   } mode_status_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIME_W-1:0] csr_wdata;

   mmc_req_if req_bus ();
   mmc_rsp_if rsp_bus ();

   mower_mode_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   req_item_type    pending_items [$];
   mode_status_type expected_status [$];
   req_item_type    on_bus;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned report_count;
   int unsigned cycle_count;
   bit          failed;

   // predictor state and timeouts
   logic [MODE_W-1:0] cur_mode;
   logic [MODE_W-1:0] prev_mode;
   logic [TIME_W-1:0] mode_ms;
   bit                latch;
   bit                blade;
   bit                drive;
   bit                charger;
   bit                refused_f;
   bit                halt_f;
   bit                border_f;
   logic [TIME_W-1:0] dock_limit;
   logic [TIME_W-1:0] border_limit;
   logic [TIME_W-1:0] rain_limit;

   function automatic logic [15:0] hot(input logic [MODE_W-1:0] m);
      return 16'd1 << m;
   endfunction

   function automatic bit move_allowed(input logic [MODE_W-1:0] from,
                                       input logic [MODE_W-1:0] to);
      logic [15:0] ok;
      case (from)
         MODE_IDLE: begin
            ok = hot(MODE_MOWING) | hot(MODE_DOCKING) | hot(MODE_MANUAL) | hot(MODE_TEST)
               | hot(MODE_SLEEP) | hot(MODE_PAUSED);
         end
         MODE_MOWING: begin
            ok = hot(MODE_IDLE) | hot(MODE_DOCKING) | hot(MODE_BORDER) | hot(MODE_LIFTED)
               | hot(MODE_PAUSED) | hot(MODE_MAINT) | hot(MODE_RAIN);
         end
         MODE_DOCKING:  ok = hot(MODE_CHARGING) | hot(MODE_IDLE);
         MODE_CHARGING: ok = hot(MODE_IDLE) | hot(MODE_MOWING);
         MODE_MANUAL:   ok = hot(MODE_IDLE) | hot(MODE_PAUSED);
         MODE_PAUSED:   ok = hot(MODE_IDLE) | hot(MODE_MOWING) | hot(MODE_MANUAL);
         MODE_RAIN:     ok = hot(MODE_IDLE) | hot(MODE_MOWING);
         MODE_REMOTE:   ok = hot(MODE_IDLE) | hot(MODE_MANUAL);
         MODE_BORDER:   ok = hot(MODE_MOWING) | hot(MODE_IDLE) | hot(MODE_DOCKING);
         MODE_SLEEP, MODE_MAINT, MODE_ESTOP, MODE_LIFTED, MODE_TEST, MODE_ERROR: begin
            ok = hot(MODE_IDLE);
         end
         default: ok = '0;
      endcase
      return ok[to];
   endfunction

   function automatic void reset_predictor();
      cur_mode = MODE_IDLE;
      prev_mode = MODE_IDLE;
      mode_ms = '0;
      latch = 1'b0;
      blade = 1'b0;
      drive = 1'b0;
      charger = 1'b0;
      dock_limit = DOCKING_TIMEOUT_RST;
      border_limit = BORDER_BACKOFF_RST;
      rain_limit = RAIN_WAIT_RST;
   endfunction

   // returns 1 when the controller sits in the target mode afterwards
   function automatic bit go_to(input logic [MODE_W-1:0] to);
      if (cur_mode == to) return 1'b1;
      if (to != MODE_ESTOP && !move_allowed(cur_mode, to)) begin
         refused_f = 1'b1;
         return 1'b0;
      end
      if (cur_mode == MODE_CHARGING) charger = 1'b0;
      prev_mode = cur_mode;
      cur_mode = to;
      mode_ms = '0;
      case (to)
         MODE_MOWING: begin
            blade = 1'b1;
            drive = 1'b1;
         end
         MODE_DOCKING: begin
            blade = 1'b0;
            drive = 1'b1;
         end
         MODE_CHARGING: begin
            blade = 1'b0;
            drive = 1'b0;
            charger = 1'b1;
         end
         MODE_ESTOP: begin
            blade = 1'b0;
            drive = 1'b0;
            halt_f = 1'b1;
            latch = 1'b1;
         end
         MODE_LIFTED: begin
            blade = 1'b0;
            drive = 1'b0;
            halt_f = 1'b1;
         end
         MODE_BORDER: border_f = 1'b1;
         MODE_TEST: ;
         default: begin
            blade = 1'b0;
            drive = 1'b0;
         end
      endcase
      return 1'b1;
   endfunction

   function automatic void run_tick(input req_item_type it);
      logic [TIME_W:0] sum;
      sum = {1'b0, mode_ms} + it.elapsed_ms;
      mode_ms = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      // emergency wins over every per-mode rule
      if ((it.lifted || latch) && cur_mode != MODE_ESTOP) begin
         void'(go_to(MODE_ESTOP));
         return;
      end
      case (cur_mode)
         MODE_MOWING: begin
            if (it.border_seen) void'(go_to(MODE_BORDER));
            else if (it.lifted) void'(go_to(MODE_LIFTED));
            if (it.battery_low) void'(go_to(MODE_DOCKING));
            else if (it.border_seen) void'(go_to(MODE_BORDER));
         end
         MODE_DOCKING: begin
            if (mode_ms > dock_limit) void'(go_to(MODE_CHARGING));
            if (it.battery_charged) void'(go_to(MODE_MOWING));
            else if (it.docked) void'(go_to(MODE_CHARGING));
         end
         MODE_CHARGING: begin
            if (!it.charging_active) void'(go_to(MODE_IDLE));
            if (it.battery_full) void'(go_to(MODE_IDLE));
            else if (!it.docked) void'(go_to(MODE_DOCKING));
         end
         MODE_SLEEP: if (it.battery_charged && it.docked) void'(go_to(MODE_CHARGING));
         MODE_RAIN: if (mode_ms > rain_limit) void'(go_to(MODE_IDLE));
         MODE_BORDER: begin
            if (mode_ms > border_limit) void'(go_to(MODE_MOWING));
            if (!it.border_seen) void'(go_to(MODE_MOWING));
         end
         MODE_LIFTED: if (!it.lifted) void'(go_to(MODE_IDLE));
         default: ;
      endcase
   endfunction

   function automatic mode_status_type predict_status(input req_item_type it);
      bit              emergency;
      mode_status_type st;
      emergency = it.lifted || latch;
      refused_f = 1'b0;
      halt_f = 1'b0;
      border_f = 1'b0;
      case (it.cmd)
         CMD_TICK:   run_tick(it);
         CMD_START:  if (!emergency) void'(go_to(MODE_MOWING));
         CMD_STOP:   if (cur_mode == MODE_MOWING) void'(go_to(MODE_IDLE));
         CMD_DOCK:   if (!emergency) void'(go_to(MODE_DOCKING));
         CMD_ESTOP:  void'(go_to(MODE_ESTOP));
         CMD_MANUAL: if (!emergency) void'(go_to(MODE_MANUAL));
         CMD_RESET_ERR: begin
            if (cur_mode == MODE_ESTOP) begin
               if (go_to(prev_mode)) latch = 1'b0;
            end
         end
         CMD_REQUEST: void'(go_to(it.target_state));
         default: ;
      endcase
      st.mode = cur_mode;
      st.prior = prev_mode;
      st.refused = refused_f;
      st.blades = blade;
      st.drive = drive;
      st.charge = charger;
      st.halt = halt_f;
      st.border = border_f;
      return st;
   endfunction

   function automatic void note_failure(input string what, input logic [MODE_W-1:0] want,
                                        input logic [MODE_W-1:0] got);
      if (report_count < MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      end
      report_count++;
      failed = 1'b1;
   endfunction

   function automatic void check_field(input string what, input logic [MODE_W-1:0] want,
                                       input logic [MODE_W-1:0] got);
      if (want !== got) note_failure(what, want, got);
   endfunction

   function automatic void check_bit(input string what, input logic want, input logic got);
      if (want !== got) begin
         note_failure(what, {{(MODE_W-1){1'b0}}, want}, {{(MODE_W-1){1'b0}}, got});
      end
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic req_item_type make_item(input logic [CMD_W-1:0] cmd,
                                              input logic [MODE_W-1:0] tgt,
                                              input logic [ELAPSED_W-1:0] el,
                                              input logic [6:0] sensors);
      req_item_type it;
      it.cmd = cmd;
      it.target_state = tgt;
      it.elapsed_ms = el;
      {it.lifted, it.battery_low, it.border_seen, it.battery_charged, it.docked,
       it.battery_full, it.charging_active} = sensors;
      return it;
   endfunction

   function automatic logic [ELAPSED_W-1:0] rand_elapsed();
      case ($urandom_range(3))
         0: return '0;
         1: return ELAPSED_W'($urandom_range(400));
         2: return ELAPSED_W'($urandom_range(5000));
         default: return ELAPSED_W'($urandom_range(65535));
      endcase
   endfunction

   // lifted is kept rare since it forces an emergency stop
   function automatic logic [6:0] rand_sensors();
      logic [6:0] s;
      s = 7'($urandom_range(63));
      if ($urandom_range(15) == 0) s = s | S_LIFTED;
      return s;
   endfunction

   function automatic req_item_type cmd_item(input logic [CMD_W-1:0] cmd);
      return make_item(cmd, MODE_W'($urandom_range(15)), rand_elapsed(), rand_sensors());
   endfunction

   function automatic req_item_type tick_item(input logic [6:0] sensors);
      return make_item(CMD_TICK, MODE_W'($urandom_range(15)), rand_elapsed(), sensors);
   endfunction

   // brings the controller back to idle with the emergency latch cleared
   function automatic void queue_recovery();
      pending_items.push_back(make_item(CMD_REQUEST, MODE_IDLE, rand_elapsed(), rand_sensors()));
      pending_items.push_back(tick_item(rand_sensors() & ~S_LIFTED));
      pending_items.push_back(make_item(CMD_RESET_ERR, MODE_W'($urandom_range(15)),
                                        rand_elapsed(), rand_sensors()));
   endfunction

   function automatic void queue_directed();
      pending_items.push_back(make_item(CMD_STOP, MODE_IDLE, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_RESET_ERR, MODE_IDLE, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_REQUEST, 4'hF, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_START, MODE_IDLE, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_TICK, MODE_IDLE, 16'hFFFF, S_BORDER));
      pending_items.push_back(make_item(CMD_TICK, MODE_IDLE, 16'd0, S_BORDER));
      pending_items.push_back(make_item(CMD_TICK, MODE_IDLE, 16'd1, S_BORDER));
      // border then docking chained on one tick
      pending_items.push_back(make_item(CMD_TICK, MODE_IDLE, 16'd5, S_BATLOW | S_BORDER));
      pending_items.push_back(make_item(CMD_TICK, MODE_IDLE, 16'd400, S_CHARGING));
      pending_items.push_back(make_item(CMD_TICK, MODE_IDLE, 16'd0, S_CHARGING | S_DOCKED));
      pending_items.push_back(make_item(CMD_TICK, MODE_IDLE, 16'd0, S_CHARGING));
      pending_items.push_back(make_item(CMD_TICK, MODE_IDLE, 16'd0, S_CHARGED));
      pending_items.push_back(make_item(CMD_STOP, MODE_IDLE, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_REQUEST, MODE_RAIN, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_REQUEST, MODE_TEST, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_ESTOP, MODE_IDLE, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_START, MODE_IDLE, 16'd0, S_NONE));
      // prior mode is test, so the reset is refused
      pending_items.push_back(make_item(CMD_RESET_ERR, MODE_IDLE, 16'd0, S_NONE));
      // leaving estop by request keeps the latch, next tick goes back
      pending_items.push_back(make_item(CMD_REQUEST, MODE_IDLE, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_TICK, MODE_IDLE, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_RESET_ERR, MODE_IDLE, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_START, MODE_IDLE, 16'd0, S_FULL));
      pending_items.push_back(make_item(CMD_REQUEST, MODE_LIFTED, 16'd0, S_NONE));
      pending_items.push_back(make_item(CMD_TICK, 4'hF, 16'hFFFF, 7'h3F));
      pending_items.push_back(make_item(CMD_MANUAL, 4'hF, 16'hFFFF, 7'h7F));
   endfunction

   function automatic void queue_random(input int unsigned count);
      int unsigned base;
      int unsigned n;
      base = pending_items.size();
      while (pending_items.size() < base + count) begin
         n = $urandom_range(1, 8);
         case ($urandom_range(9))
            0, 1: begin
               pending_items.push_back(cmd_item(CMD_START));
               repeat (n) pending_items.push_back(tick_item(rand_sensors()));
            end
            2: begin
               pending_items.push_back(cmd_item(CMD_START));
               pending_items.push_back(tick_item((rand_sensors() | S_BORDER) & ~S_BATLOW));
               repeat (n) begin
                  pending_items.push_back(tick_item($urandom_range(3) != 0 ?
                     rand_sensors() | S_BORDER : rand_sensors()));
               end
            end
            3, 4: begin
               pending_items.push_back(cmd_item(CMD_DOCK));
               repeat (n) begin
                  pending_items.push_back(tick_item($urandom_range(3) != 0 ?
                     rand_sensors() | S_CHARGING : rand_sensors()));
               end
            end
            5: queue_recovery();
            6: begin
               pending_items.push_back(cmd_item(CMD_REQUEST));
               repeat (n) pending_items.push_back(tick_item(rand_sensors()));
            end
            7: begin
               queue_recovery();
               if ($urandom_range(1) != 0) begin
                  pending_items.push_back(make_item(CMD_REQUEST, MODE_SLEEP, rand_elapsed(),
                                                    S_NONE));
               end else begin
                  pending_items.push_back(make_item(CMD_START, 4'd0, rand_elapsed(), S_NONE));
                  pending_items.push_back(make_item(CMD_REQUEST, MODE_RAIN, rand_elapsed(),
                                                    S_NONE));
               end
               repeat (n) pending_items.push_back(tick_item(rand_sensors() & ~S_LIFTED));
            end
            8: pending_items.push_back(cmd_item(CMD_W'($urandom_range(7))));
            default: begin
               pending_items.push_back(make_item(CMD_W'($urandom_range(7)),
                                                 MODE_W'($urandom_range(15)),
                                                 ELAPSED_W'($urandom_range(65535)),
                                                 7'($urandom_range(127))));
            end
         endcase
      end
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || expected_status.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_timeouts(input logic [TIME_W-1:0] dock, input logic [TIME_W-1:0] bord,
                                 input logic [TIME_W-1:0] rain);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_DOCKING_TIMEOUT;
      csr_wdata <= dock;
      @(posedge clock);
      csr_index <= CSR_BORDER_BACKOFF;
      csr_wdata <= bord;
      @(posedge clock);
      csr_index <= CSR_RAIN_WAIT;
      csr_wdata <= rain;
      @(posedge clock);
      csr_we <= 1'b0;
      dock_limit = dock;
      border_limit = bord;
      rain_limit = rain;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- clock, driver, monitor

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         reset_predictor();
      end else begin
         if (req_bus.valid && req_bus.ready) expected_status.push_back(predict_status(on_bus));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = pending_items.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.cmd <= on_bus.cmd;
               req_bus.target_state <= on_bus.target_state;
               req_bus.elapsed_ms <= on_bus.elapsed_ms;
               req_bus.lifted <= on_bus.lifted;
               req_bus.battery_low <= on_bus.battery_low;
               req_bus.border_seen <= on_bus.border_seen;
               req_bus.battery_charged <= on_bus.battery_charged;
               req_bus.docked <= on_bus.docked;
               req_bus.battery_full <= on_bus.battery_full;
               req_bus.charging_active <= on_bus.charging_active;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_status.size() == 0) begin
               note_failure("unexpected transfer, mode", 'x, rsp_bus.mode);
            end else begin
               mode_status_type want;
               want = expected_status.pop_front();
               check_field("mode", want.mode, rsp_bus.mode);
               check_field("prior_mode", want.prior, rsp_bus.prior_mode);
               check_bit("refused", want.refused, rsp_bus.refused);
               check_bit("blades_on", want.blades, rsp_bus.blades_on);
               check_bit("drive_on", want.drive, rsp_bus.drive_on);
               check_bit("charge_enable", want.charge, rsp_bus.charge_enable);
               check_bit("halt_pulse", want.halt, rsp_bus.halt_pulse);
               check_bit("border_pulse", want.border, rsp_bus.border_pulse);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------- test sequence

   initial begin
      failed = 1'b0;
      report_count = 0;
      send_idle_pct = 16;
      recv_idle_pct = 76;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_TICK;
      req_bus.target_state = MODE_IDLE;
      req_bus.elapsed_ms = '0;
      req_bus.lifted = 1'b0;
      req_bus.battery_low = 1'b0;
      req_bus.border_seen = 1'b0;
      req_bus.battery_charged = 1'b0;
      req_bus.docked = 1'b0;
      req_bus.battery_full = 1'b0;
      req_bus.charging_active = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      write_timeouts(32'd300, 32'd0, 32'd0);
      queue_directed();
      queue_random(570);
      wait_drained();

      send_idle_pct = 76;
      recv_idle_pct = 16;
      write_timeouts('1, '1, 32'd70000);
      queue_random(570);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_timeouts($urandom_range(3000), $urandom_range(3000), $urandom_range(20000));
      queue_random(570);
      wait_drained();

      repeat (4) @(posedge clock);
      if (!failed) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
